FILE: rtl/source_front_time_lag_assert.svh
`ifndef SOURCE_FRONT_TIME_LAG_ASSERT_SVH
`define SOURCE_FRONT_TIME_LAG_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SFTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("source_front_time_lag: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SFTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("source_front_time_lag: next-cycle check failed");

`endif

FILE: rtl/sftl_pkg.sv
package sftl_pkg;

	// Coordinate and time words are signed Q16.16.
	localparam int CoordW  = 32;
	localparam int FracW   = 16;
	localparam int DataW   = 32;
	localparam int AddrW   = 5;

	// Sphere path: absolute differences, exact squares and their sum.
	localparam int DiffW   = CoordW + 1;
	localparam int SqW     = 2 * CoordW;
	localparam int SumW    = SqW + 2;
	localparam int RootW   = SumW / 2 + 1;
	localparam int TrialW  = 2 * RootW;

	// Plane path: exact products of direction and offset, and their sum.
	localparam int PpW     = CoordW + DiffW;
	localparam int PsumW   = PpW + 2;
	localparam int PlaneRW = PsumW - 1 - FracW;

	// Lag product, split into two partial products.
	localparam int RW      = PlaneRW;
	localparam int SplitW  = RW / 2;
	localparam int PartW   = (RW - SplitW) + CoordW;
	localparam int ProdW   = RW + CoordW;
	localparam int LagW    = 41;
	localparam int ResW    = LagW + 1;

	localparam logic [LagW-1:0]   LagCap = {1'b1, {(LagW - 1){1'b0}}};
	localparam logic [CoordW-1:0] MinQ   = {1'b1, {(CoordW - 1){1'b0}}};
	localparam logic [CoordW-1:0] MaxQ   = {1'b0, {(CoordW - 1){1'b1}}};

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_SPHERE = 2'd1,
		MODE_PLANE  = 2'd2
	} lag_mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_VEC_X,
		REG_VEC_Y,
		REG_VEC_Z,
		REG_CORNER_X,
		REG_CORNER_Y,
		REG_CORNER_Z,
		REG_SPEED
	} reg_idx_t;

	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic signed [CoordW-1:0] time_in;
	} point_t;

	typedef struct packed {
		logic signed [CoordW-1:0] lagged_time;
		logic                     saturated;
	} result_t;

	// Data that rides alongside the square root pipeline.
	typedef struct packed {
		logic [PlaneRW-1:0]       r_plane;
		logic signed [CoordW-1:0] time_in;
	} side_t;

endpackage

FILE: rtl/sftl_sqrt.sv
module sftl_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         x_valid,
	input  logic [sftl_pkg::SumW-1:0]    x,
	input  sftl_pkg::side_t              x_side,
	output logic                         root_valid,
	output logic [sftl_pkg::RootW-1:0]   root,
	output sftl_pkg::side_t              root_side
);

	localparam int Stages = sftl_pkg::RootW;

	logic                         v_s    [Stages];
	logic [sftl_pkg::SumW-1:0]    rem_s  [Stages];
	logic [sftl_pkg::RootW-1:0]   root_s [Stages];
	sftl_pkg::side_t              side_s [Stages];

	// Each stage settles one root bit, most significant first, by trying to
	// subtract the square increment from the running remainder.
	for (genvar k = 0; k < Stages; k++) begin : g_stage
		localparam int B = sftl_pkg::RootW - 1 - k;

		logic                         v_in;
		logic [sftl_pkg::SumW-1:0]    rem_in;
		logic [sftl_pkg::RootW-1:0]   root_in;
		sftl_pkg::side_t              side_in;
		logic [sftl_pkg::TrialW-1:0]  trial;
		logic                         take;

		if (k == 0) begin : g_first
			assign v_in    = x_valid;
			assign rem_in  = x;
			assign root_in = '0;
			assign side_in = x_side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = (sftl_pkg::TrialW'(root_in) << (B + 1))
			| (sftl_pkg::TrialW'(1) << (2 * B));
		assign take  = sftl_pkg::TrialW'(rem_in) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_in - sftl_pkg::SumW'(trial) : rem_in;
				root_s[k] <= root_in | (sftl_pkg::RootW'(take) << B);
				side_s[k] <= side_in;
			end
		end
	end

	assign root_valid = v_s[Stages-1];
	assign root       = root_s[Stages-1];
	assign root_side  = side_s[Stages-1];

endmodule

FILE: rtl/source_front_time_lag.sv
// Channel   Direction  Handshake                     Payload
// point     in         point_valid / point_ready     sftl_pkg::point_t
// result    out        result_valid / result_ready   sftl_pkg::result_t
// config    in         APB psel/penable/pwrite       8 registers of 32 bits
//
// One transaction is accepted per cycle while the skid register is empty.
// The square root settles one of its 34 root bits per stage.
// Reset (arst_n low) clears all valid bits, the skid stage and the registers.
// A stalled result moves into a one-entry skid register; the pipeline freezes only
// while that register is full, so no transaction is lost or repeated.
module source_front_time_lag (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sftl_pkg::AddrW-1:0]    paddr,
	input  logic [sftl_pkg::DataW-1:0]    pwdata,
	output logic [sftl_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  sftl_pkg::point_t              point,
	output logic                          result_valid,
	input  logic                          result_ready,
	output sftl_pkg::result_t             result
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete in the APB access phase,
	// and reads return the stored value of the addressed register.
	// ------------------------------------------------------------------
	logic [1:0]                        mode_q;
	logic signed [sftl_pkg::CoordW-1:0] vec_q    [3];
	logic signed [sftl_pkg::CoordW-1:0] corner_q [3];
	logic [sftl_pkg::CoordW-1:0]       speed_q;

	sftl_pkg::reg_idx_t idx;
	logic               wr;

	assign pready = 1'b1;
	assign idx    = sftl_pkg::reg_idx_t'(paddr[sftl_pkg::AddrW-1:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			speed_q <= '0;
			for (int i = 0; i < 3; i++) begin
				vec_q[i]    <= '0;
				corner_q[i] <= '0;
			end
		end else if (wr) begin
			unique case (idx)
				sftl_pkg::REG_MODE:     mode_q      <= pwdata[1:0];
				sftl_pkg::REG_VEC_X:    vec_q[0]    <= pwdata;
				sftl_pkg::REG_VEC_Y:    vec_q[1]    <= pwdata;
				sftl_pkg::REG_VEC_Z:    vec_q[2]    <= pwdata;
				sftl_pkg::REG_CORNER_X: corner_q[0] <= pwdata;
				sftl_pkg::REG_CORNER_Y: corner_q[1] <= pwdata;
				sftl_pkg::REG_CORNER_Z: corner_q[2] <= pwdata;
				sftl_pkg::REG_SPEED:    speed_q     <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sftl_pkg::REG_MODE:     prdata = sftl_pkg::DataW'(mode_q);
			sftl_pkg::REG_VEC_X:    prdata = vec_q[0];
			sftl_pkg::REG_VEC_Y:    prdata = vec_q[1];
			sftl_pkg::REG_VEC_Z:    prdata = vec_q[2];
			sftl_pkg::REG_CORNER_X: prdata = corner_q[0];
			sftl_pkg::REG_CORNER_Y: prdata = corner_q[1];
			sftl_pkg::REG_CORNER_Z: prdata = corner_q[2];
			sftl_pkg::REG_SPEED:    prdata = speed_q;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. The whole pipeline advances together while the skid
	// register is empty. If the last stage holds a result that the sink
	// does not take, that result parks in the skid register and the
	// pipeline freezes until the sink drains it.
	// ------------------------------------------------------------------
	logic              en;
	logic              skid_valid_q;
	sftl_pkg::result_t skid_q;

	assign en          = !skid_valid_q;
	assign point_ready = en;

	// ------------------------------------------------------------------
	// Datapath stages. Stages s1 to s5 build both distance inputs, the
	// square root pipeline sits between s5 and s6, and s6 to s9 scale
	// the distance and subtract it from the time.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// s1: input register.
	sftl_pkg::point_t pt_s1;

	// s2: sphere absolute differences and plane offsets.
	logic signed [sftl_pkg::CoordW-1:0] pos      [3];
	logic signed [sftl_pkg::DiffW-1:0]  dsph     [3];
	logic [sftl_pkg::CoordW-1:0]        dabs     [3];
	logic signed [sftl_pkg::DiffW-1:0]  dpl      [3];
	logic [sftl_pkg::CoordW-1:0]        dabs_s2  [3];
	logic signed [sftl_pkg::DiffW-1:0]  dpl_s2   [3];
	logic signed [sftl_pkg::CoordW-1:0] t_s2;

	assign pos[0] = pt_s1.pos_x;
	assign pos[1] = pt_s1.pos_y;
	assign pos[2] = pt_s1.pos_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsph[i] = sftl_pkg::DiffW'(vec_q[i]) - sftl_pkg::DiffW'(pos[i]);
			dabs[i] = dsph[i][sftl_pkg::DiffW-1] ? sftl_pkg::CoordW'(-dsph[i])
				: sftl_pkg::CoordW'(dsph[i]);
			dpl[i]  = sftl_pkg::DiffW'(corner_q[i]) - sftl_pkg::DiffW'(pos[i]);
		end
	end

	// s3: exact squares and exact direction products for every lane.
	logic [sftl_pkg::SqW-1:0]         sq_s3 [3];
	logic signed [sftl_pkg::PpW-1:0]  pp_s3 [3];
	logic signed [sftl_pkg::CoordW-1:0] t_s3;

	// s4: lane sums.
	logic [sftl_pkg::SumW-1:0]         ssum_s4;
	logic signed [sftl_pkg::PsumW-1:0] psum_s4;
	logic signed [sftl_pkg::CoordW-1:0] t_s4;

	// s5: plane distance. Truncating toward zero and then taking the
	// magnitude is the same as shifting the magnitude of the sum.
	logic signed [sftl_pkg::PsumW-1:0] pabs;
	logic [sftl_pkg::SumW-1:0]         x_s5;
	logic [sftl_pkg::PlaneRW-1:0]      rpl_s5;
	logic signed [sftl_pkg::CoordW-1:0] t_s5;
	sftl_pkg::side_t                   side_s5;

	assign pabs = psum_s4[sftl_pkg::PsumW-1] ? -psum_s4 : psum_s4;

	assign side_s5.r_plane = rpl_s5;
	assign side_s5.time_in = t_s5;

	// Square root of the summed squares gives the sphere distance.
	logic                         rt_valid;
	logic [sftl_pkg::RootW-1:0]   rt_root;
	sftl_pkg::side_t              rt_side;

	sftl_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.x_valid    (v_s5),
		.x          (x_s5),
		.x_side     (side_s5),
		.root_valid (rt_valid),
		.root       (rt_root),
		.root_side  (rt_side)
	);

	// s6: pick the distance for the mode and form two partial products
	// with the reciprocal speed. Mode values 0 (off) and 3 give zero distance.
	logic [sftl_pkg::RW-1:0]            rsel;
	logic [sftl_pkg::PartW-1:0]         pl_s6;
	logic [sftl_pkg::PartW-1:0]         ph_s6;
	logic signed [sftl_pkg::CoordW-1:0] t_s6;

	always_comb begin
		unique case (mode_q)
			sftl_pkg::MODE_SPHERE: rsel = sftl_pkg::RW'(rt_root);
			sftl_pkg::MODE_PLANE:  rsel = rt_side.r_plane;
			default:               rsel = '0;
		endcase
	end

	// s7: full lag product.
	logic [sftl_pkg::ProdW-1:0]         prod_s7;
	logic signed [sftl_pkg::CoordW-1:0] t_s7;

	// s8: drop the fraction and cap the lag, which keeps the subtraction
	// narrow while still forcing saturation for any oversized lag.
	logic [sftl_pkg::LagW-1:0]          lag_s8;
	logic signed [sftl_pkg::CoordW-1:0] t_s8;

	// s9: subtract and clamp to the Q16.16 range.
	logic signed [sftl_pkg::ResW-1:0]   dres;
	logic                               ovf;
	sftl_pkg::result_t                  res_s9;

	assign dres = sftl_pkg::ResW'(t_s8) - $signed(sftl_pkg::ResW'(lag_s8));
	assign ovf  = dres[sftl_pkg::ResW-1:sftl_pkg::CoordW-1]
		!= {(sftl_pkg::ResW - sftl_pkg::CoordW + 1){dres[sftl_pkg::ResW-1]}};

	// Valid bits and the skid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			v_s7         <= 1'b0;
			v_s8         <= 1'b0;
			v_s9         <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1         <= point_valid;
				v_s2         <= v_s1;
				v_s3         <= v_s2;
				v_s4         <= v_s3;
				v_s5         <= v_s4;
				v_s6         <= rt_valid;
				v_s7         <= v_s6;
				v_s8         <= v_s7;
				v_s9         <= v_s8;
				skid_valid_q <= v_s9 && !result_ready;
			end else if (result_ready) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; the valid bits qualify them.
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= point;

			for (int i = 0; i < 3; i++) begin
				dabs_s2[i] <= dabs[i];
				dpl_s2[i]  <= dpl[i];
				sq_s3[i]   <= sftl_pkg::SqW'(dabs_s2[i]) * sftl_pkg::SqW'(dabs_s2[i]);
				pp_s3[i]   <= $signed(vec_q[i]) * $signed(dpl_s2[i]);
			end
			t_s2 <= pt_s1.time_in;
			t_s3 <= t_s2;

			ssum_s4 <= sftl_pkg::SumW'(sq_s3[0]) + sftl_pkg::SumW'(sq_s3[1])
				+ sftl_pkg::SumW'(sq_s3[2]);
			psum_s4 <= sftl_pkg::PsumW'(pp_s3[0]) + sftl_pkg::PsumW'(pp_s3[1])
				+ sftl_pkg::PsumW'(pp_s3[2]);
			t_s4    <= t_s3;

			x_s5   <= ssum_s4;
			rpl_s5 <= pabs[sftl_pkg::PsumW-2:sftl_pkg::FracW];
			t_s5   <= t_s4;

			pl_s6 <= sftl_pkg::PartW'(rsel[sftl_pkg::SplitW-1:0])
				* sftl_pkg::PartW'(speed_q);
			ph_s6 <= sftl_pkg::PartW'(rsel[sftl_pkg::RW-1:sftl_pkg::SplitW])
				* sftl_pkg::PartW'(speed_q);
			t_s6  <= rt_side.time_in;

			prod_s7 <= sftl_pkg::ProdW'({ph_s6, {sftl_pkg::SplitW{1'b0}}})
				+ sftl_pkg::ProdW'(pl_s6);
			t_s7    <= t_s6;

			lag_s8 <= (|prod_s7[sftl_pkg::ProdW-1:sftl_pkg::LagW-1+sftl_pkg::FracW])
				? sftl_pkg::LagCap
				: sftl_pkg::LagW'(prod_s7[sftl_pkg::LagW-2+sftl_pkg::FracW:sftl_pkg::FracW]);
			t_s8   <= t_s7;

			res_s9.lagged_time <= ovf
				? (dres[sftl_pkg::ResW-1] ? sftl_pkg::MinQ : sftl_pkg::MaxQ)
				: dres[sftl_pkg::CoordW-1:0];
			res_s9.saturated   <= ovf;
		end

		if (en && v_s9 && !result_ready) begin
			skid_q <= res_s9;
		end
	end

	// The skid register, when full, holds the oldest result.
	assign result_valid = skid_valid_q || v_s9;
	assign result       = skid_valid_q ? skid_q : res_s9;

endmodule

FILE: rtl/sftl_checker.sv
`include "source_front_time_lag_assert.svh"

module sftl_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [sftl_pkg::AddrW-1:0]    paddr,
	input  logic [sftl_pkg::DataW-1:0]    pwdata,
	input  logic [sftl_pkg::DataW-1:0]    prdata,
	input  logic                          point_ready,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  sftl_pkg::result_t             result
);

	// A result that is not taken stays offered and unchanged.
	`SFTL_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// The input side only stalls while a finished result is waiting.
	`SFTL_ASSERT_IMP(a_stall_cause, clk, arst_n, !point_ready, result_valid)

	// A refused result taken with input open fills the skid stage and closes the input.
	`SFTL_ASSERT_NXT(a_skid_fill, clk, arst_n, result_valid && !result_ready && point_ready, !point_ready)

	// A full-width register reads back what was just written to it.
	`SFTL_ASSERT_NXT(a_readback, clk, arst_n, psel && penable && pwrite && pready && (paddr[sftl_pkg::AddrW-1:2] != sftl_pkg::REG_MODE), (paddr[sftl_pkg::AddrW-1:2] != $past(paddr[sftl_pkg::AddrW-1:2])) || (prdata == $past(pwdata)))

endmodule

bind source_front_time_lag sftl_checker u_sftl_checker (.*);
